### hw/rtl/fta_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the frame time averager
package fta_pkg;

  localparam int DATA_W = 64;
  localparam int RATE_W = 32;
  localparam int OP_W   = 2;

  localparam logic [RATE_W-1:0] TPS_RESET = 32'd10000000;

  // event codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET = 2'd3;

  typedef logic [DATA_W-1:0] ticks_t;
  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [OP_W-1:0]   op_t;

  // sequencer to window store controls
  typedef struct packed {
    logic rd_oldest;
    logic push;
  } win_ctrl_t;

endpackage

### hw/rtl/fta_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for event items and result items
interface fta_in_if;
  logic             valid;
  logic             ready;
  fta_pkg::op_t     opcode;
  fta_pkg::ticks_t  counter_value;

  modport source (output valid, output opcode, output counter_value, input ready);
  modport sink   (input valid, input opcode, input counter_value, output ready);
endinterface

interface fta_out_if;
  logic             valid;
  logic             ready;
  fta_pkg::ticks_t  average_ticks;
  fta_pkg::rate_t   frame_rate;
  fta_pkg::ticks_t  total_ticks;
  logic             is_stopped;

  modport source (output valid, output average_ticks, output frame_rate,
                  output total_ticks, output is_stopped, input ready);
  modport sink   (input valid, input average_ticks, input frame_rate,
                  input total_ticks, input is_stopped, output ready);
endinterface

### hw/rtl/fta_window.sv
`timescale 1ns / 1ps
// ring buffer of frame deltas with fill count and running window sum
module fta_window #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7,
  parameter int SUM_W = 71,
  parameter int PTR_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fta_pkg::win_ctrl_t  ctrl,
  input  fta_pkg::ticks_t     din,
  output logic [CNT_W-1:0]    cnt,
  output logic [SUM_W-1:0]    sum
);

  fta_pkg::ticks_t   mem [DEPTH];
  fta_pkg::ticks_t   old_r;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              full;

  assign full = (cnt_r == CNT_W'(DEPTH));

  // once full, the write slot holds the oldest entry
  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign sum_nxt    = sum_r + SUM_W'(din) - (full ? SUM_W'(old_r) : '0);

  // memory port: read oldest ahead of a push, write newest on push
  always_ff @(posedge clk) begin
    if (ctrl.rd_oldest) begin
      old_r <= mem[wr_ptr_r];
    end
    if (ctrl.push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  // pointer, fill count and window sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
    end else if (ctrl.push) begin
      wr_ptr_r <= wr_ptr_nxt;
      sum_r    <= sum_nxt;
      if (!full) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign cnt = cnt_r;
  assign sum = sum_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("window fill count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push && full |=> cnt_r == CNT_W'(DEPTH))
    else $error("fill count moved on a full push");

  a_push_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push && !full |=> sum_r == $past(sum_r) + SUM_W'($past(din)))
    else $error("window sum not advanced by new delta");
`endif

endmodule

### hw/rtl/fta_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module fta_div #(
  parameter int DW = 71,
  parameter int NW = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [NW-1:0]  divisor,
  output logic           busy,
  output logic           done,
  output logic [DW-1:0]  quotient
);

  localparam int STEP_W = $clog2(DW + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DW-1:0]     dvd_r;
  logic [NW-1:0]     dvs_r;
  logic [NW-1:0]     rem_r;
  logic [NW:0]       rem_sh;
  logic [NW:0]       rem_nxt;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;

  // datapath: quotient bits fill dvd_r from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= rem_nxt[NW-1:0];
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DW - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still stepping");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");
`endif

endmodule

### hw/rtl/frame_time_averager_top.sv
`timescale 1ns / 1ps
// frame time averager top: event sequencer, timer state and result register
// a running tick with a nonempty window takes its average from the bit-serial divide of
// the window sum by the fill count; input is accepted only in S_IDLE, and the sequencer
// waits in S_FIN2 while the previous result is still held on the output
// synchronous active-low reset clears all timer state and loads 10000000 ticks/s
// the delta memory is not cleared; a slot read before the window fills is left out of the sum
module frame_time_averager_top #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  fta_in_if.sink                 in_chan,
  fta_out_if.source              out_chan,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = fta_pkg::DATA_W + CNT_W;
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVENT = 4'd1;
  localparam logic [3:0] S_PAUSE = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_STORE = 4'd4;
  localparam logic [3:0] S_AVG   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN1  = 4'd7;
  localparam logic [3:0] S_FIN2  = 4'd8;

  logic [3:0]           state_r;
  fta_pkg::op_t         op_r;
  fta_pkg::ticks_t      now_r;
  fta_pkg::rate_t       tps_r;
  fta_pkg::ticks_t      last_r;
  fta_pkg::ticks_t      current_r;
  fta_pkg::ticks_t      base_r;
  fta_pkg::ticks_t      stop_r;
  fta_pkg::ticks_t      paused_r;
  logic                 stopped_r;
  fta_pkg::rate_t       frames_r;
  fta_pkg::rate_t       latched_r;
  fta_pkg::ticks_t      acc_r;
  fta_pkg::ticks_t      avg_r;
  fta_pkg::ticks_t      delta_r;
  fta_pkg::ticks_t      diff_r;
  fta_pkg::ticks_t      tmp_r;

  logic                 out_valid_r;
  fta_pkg::ticks_t      out_avg_r;
  fta_pkg::rate_t       out_rate_r;
  fta_pkg::ticks_t      out_total_r;
  logic                 out_stopped_r;

  fta_pkg::win_ctrl_t   win_ctrl;
  logic [CNT_W-1:0]     win_cnt;
  logic [SUM_W-1:0]     win_sum;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quo;

  logic                 in_fire;
  logic                 out_load;
  logic [fta_pkg::DATA_W:0] acc_sum;
  fta_pkg::ticks_t      endpoint;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_FIN2) && (!out_valid_r || out_chan.ready);
  assign acc_sum  = {1'b0, acc_r} + {1'b0, delta_r};
  assign endpoint = stopped_r ? stop_r : current_r;

  assign in_chan.ready = (state_r == S_IDLE) && rst_n;

  // window and divider controls
  always_comb begin
    win_ctrl.rd_oldest = (state_r == S_EVENT) && (op_r == fta_pkg::OP_TICK) && !stopped_r;
    win_ctrl.push      = (state_r == S_STORE) && (diff_r < fta_pkg::ticks_t'(tps_r));
    div_start          = (state_r == S_AVG) && (win_cnt != '0);
  end

  fta_window #(
    .DEPTH (WINDOW_DEPTH),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .PTR_W (PTR_W)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (win_ctrl),
    .din   (delta_r),
    .cnt   (win_cnt),
    .sum   (win_sum)
  );

  fta_div #(
    .DW (SUM_W),
    .NW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (win_cnt),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // captured item and scratch values
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_chan.opcode;
      now_r <= in_chan.counter_value;
    end
    if (state_r == S_EVENT) begin
      delta_r <= now_r - last_r;
      tmp_r   <= now_r - stop_r;
    end
    if (state_r == S_DIFF) begin
      diff_r <= (delta_r >= avg_r) ? (delta_r - avg_r) : (avg_r - delta_r);
    end
    if (state_r == S_FIN1) begin
      tmp_r <= endpoint - paused_r;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= fta_pkg::TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  // event sequencer and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      last_r    <= '0;
      current_r <= '0;
      base_r    <= '0;
      stop_r    <= '0;
      paused_r  <= '0;
      stopped_r <= 1'b0;
      frames_r  <= '0;
      latched_r <= '0;
      acc_r     <= '0;
      avg_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EVENT;
          end
        end
        S_EVENT: begin
          unique case (op_r)
            fta_pkg::OP_TICK: begin
              if (stopped_r) begin
                avg_r   <= '0;
                state_r <= S_FIN1;
              end else begin
                current_r <= now_r;
                last_r    <= now_r;
                state_r   <= S_DIFF;
              end
            end
            fta_pkg::OP_STOP: begin
              if (!stopped_r) begin
                stop_r    <= now_r;
                stopped_r <= 1'b1;
              end
              state_r <= S_FIN1;
            end
            fta_pkg::OP_START: begin
              state_r <= stopped_r ? S_PAUSE : S_FIN1;
            end
            fta_pkg::OP_RESET: begin
              base_r    <= now_r;
              last_r    <= now_r;
              stop_r    <= '0;
              stopped_r <= 1'b0;
              state_r   <= S_FIN1;
            end
            default: begin
              state_r <= S_FIN1;
            end
          endcase
        end
        S_PAUSE: begin
          paused_r  <= paused_r + tmp_r;
          last_r    <= now_r;
          stop_r    <= '0;
          stopped_r <= 1'b0;
          state_r   <= S_FIN1;
        end
        S_DIFF: begin
          if (frames_r != '1) begin
            frames_r <= frames_r + 1'b1;
          end
          acc_r   <= acc_sum[fta_pkg::DATA_W] ? '1 : acc_sum[fta_pkg::DATA_W-1:0];
          state_r <= S_STORE;
        end
        S_STORE: begin
          // latch the frame rate once more than a second has gone by
          if (acc_r > fta_pkg::ticks_t'(tps_r)) begin
            latched_r <= frames_r;
            frames_r  <= '0;
            acc_r     <= '0;
          end
          state_r <= S_AVG;
        end
        S_AVG: begin
          if (win_cnt == '0) begin
            avg_r   <= '0;
            state_r <= S_FIN1;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg_r   <= div_quo[fta_pkg::DATA_W-1:0];
            state_r <= S_FIN1;
          end
        end
        S_FIN1: begin
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg_r     <= avg_r;
      out_rate_r    <= latched_r;
      out_total_r   <= tmp_r - base_r;
      out_stopped_r <= stopped_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.average_ticks = out_avg_r;
  assign out_chan.frame_rate    = out_rate_r;
  assign out_chan.total_ticks   = out_total_r;
  assign out_chan.is_stopped    = out_stopped_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_chan.ready)
    else $error("item accepted while previous item in work");

  a_div_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> win_cnt != '0 && !div_busy)
    else $error("divide started on empty window or busy divider");

  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_done |=> state_r == S_FIN1)
    else $error("sequencer missed divider done");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !stopped_r |-> stop_r == '0 || state_r != S_IDLE || $past(op_r) == fta_pkg::OP_TICK
      || $past(op_r) == fta_pkg::OP_STOP)
    else $error("stop count left set while running");
`endif

endmodule
